FILE: rtl/fdd_pkg.sv
// ----------------------------------------------------------------------------
// fdd_pkg
// Shared widths, register map and reset values for the decimal digit block.
// ----------------------------------------------------------------------------
package fdd_pkg;

	localparam int NUM_W    = 32;
	localparam int WORK_W   = 35;
	localparam int DIFF_W   = WORK_W + 1;
	localparam int DIGIT_W  = 4;
	localparam int ADDR_W   = 3;
	localparam int DIV_CNT_W = 5;

	localparam logic [NUM_W-1:0] NUMERATOR_RESET   = 32'd355;
	localparam logic [NUM_W-1:0] DENOMINATOR_RESET = 32'd113;

	// register index taken from the word address bit
	localparam logic REG_NUMERATOR   = 1'b0;
	localparam logic REG_DENOMINATOR = 1'b1;

	localparam logic [DIGIT_W-1:0] DIGIT_TOP = 4'd3;

	function automatic logic [NUM_W-1:0] magnitude(input logic [NUM_W-1:0] v);
		logic [NUM_W-1:0] m;
		m = v[NUM_W-1] ? (~v + {{(NUM_W-1){1'b0}}, 1'b1}) : v;
		return m;
	endfunction

endpackage

FILE: rtl/fraction_decimal_digit.sv
// ----------------------------------------------------------------------------
// fraction_decimal_digit
// One digit of the decimal expansion of numerator / denominator.
// ----------------------------------------------------------------------------
// Usage:
// numerator and denominator are written over the APB port (word 0 and 1)
// while the block is idle. A transaction starts with start high while busy
// is low; position names the digit after the decimal point. The block
// answers with one result on a one-cycle done strobe: sign, integer part of
// the magnitude quotient, the digit, the ended flag and divide_by_zero.
// A zero denominator answers on the next cycle. Otherwise one
// subtractor is reused: restoring division for the integer part,
// then for each digit position one times-ten step and four
// compare/subtract steps. Once the remainder reaches zero the block
// stops early and answers with ended set.
// busy is high from the accepting edge until done, except for a zero
// denominator; one item is worked on at a time.
// The receiver cannot stall: the result is valid only in the done cycle.
// Reset returns the sequencer to idle and loads numerator 355, denominator
// 113.
// ----------------------------------------------------------------------------
module fraction_decimal_digit #(
	parameter int POSITION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fdd_pkg::ADDR_W-1:0]    paddr,
	input  logic [fdd_pkg::NUM_W-1:0]     pwdata,
	output logic [fdd_pkg::NUM_W-1:0]     prdata,
	output logic                          pready,
	input  logic                          start,
	input  logic [POSITION_BITS-1:0]      position,
	output logic                          busy,
	output logic                          done,
	output logic                          negative,
	output logic [fdd_pkg::NUM_W-1:0]     integer_part,
	output logic [fdd_pkg::DIGIT_W-1:0]   digit,
	output logic                          ended,
	output logic                          divide_by_zero
);
	import fdd_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_SUB} state_t;

	state_t               state_q;
	logic [NUM_W-1:0]     numerator_q;
	logic [NUM_W-1:0]     denominator_q;
	logic [NUM_W-1:0]     ad_q;
	logic [NUM_W-1:0]     quo_q;
	logic [WORK_W-1:0]    w_q;
	logic [POSITION_BITS-1:0] cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [1:0]           k_q;
	logic [DIGIT_W-1:0]   dig_q;
	logic                 neg_q;
	logic                 done_q;
	logic                 negative_q;
	logic [NUM_W-1:0]     integer_part_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic                 ended_q;
	logic                 divide_by_zero_q;

	logic                 cfg_wr;
	logic                 accept;
	logic [WORK_W-1:0]    sub_a;
	logic [WORK_W-1:0]    sub_b;
	logic [DIFF_W-1:0]    diff;
	logic                 ge;
	logic [WORK_W-1:0]    sub_res;
	logic [WORK_W-1:0]    ad_ext;
	logic [WORK_W-1:0]    times_ten;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DENOMINATOR) ? denominator_q : numerator_q;
	assign cfg_wr = psel & penable & pwrite;
	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	assign ad_ext    = {{(WORK_W-NUM_W){1'b0}}, ad_q};
	assign times_ten = (w_q << 3) + (w_q << 1);

	// shared compare/subtract unit
	always_comb begin
		if (state_q == S_DIV) begin
			sub_a = {{(WORK_W-NUM_W-1){1'b0}}, w_q[NUM_W-1:0], quo_q[NUM_W-1]};
			sub_b = ad_ext;
		end else begin
			sub_a = w_q;
			sub_b = ad_ext << k_q;
		end
		diff    = {1'b0, sub_a} - {1'b0, sub_b};
		ge      = ~diff[DIFF_W-1];
		sub_res = ge ? diff[WORK_W-1:0] : sub_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q   <= NUMERATOR_RESET;
			denominator_q <= DENOMINATOR_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DENOMINATOR) begin
				denominator_q <= pwdata;
			end else begin
				numerator_q <= pwdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			done_q           <= 1'b0;
			negative_q       <= 1'b0;
			integer_part_q   <= '0;
			digit_q          <= '0;
			ended_q          <= 1'b0;
			divide_by_zero_q <= 1'b0;
			ad_q             <= '0;
			quo_q            <= '0;
			w_q              <= '0;
			cnt_q            <= '0;
			div_cnt_q        <= '0;
			k_q              <= '0;
			dig_q            <= '0;
			neg_q            <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (denominator_q == '0) begin
							done_q           <= 1'b1;
							negative_q       <= 1'b0;
							integer_part_q   <= '0;
							digit_q          <= '0;
							ended_q          <= 1'b0;
							divide_by_zero_q <= 1'b1;
						end else begin
							ad_q      <= magnitude(denominator_q);
							quo_q     <= magnitude(numerator_q);
							w_q       <= '0;
							cnt_q     <= position;
							div_cnt_q <= '0;
							neg_q     <= (numerator_q != '0) &
							             (numerator_q[NUM_W-1] ^ denominator_q[NUM_W-1]);
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					w_q       <= sub_res;
					quo_q     <= {quo_q[NUM_W-2:0], ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == '1) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (w_q == '0) begin
						// expansion has terminated
						done_q           <= 1'b1;
						negative_q       <= neg_q;
						integer_part_q   <= quo_q;
						digit_q          <= '0;
						ended_q          <= 1'b1;
						divide_by_zero_q <= 1'b0;
						state_q          <= S_IDLE;
					end else begin
						w_q     <= times_ten;
						k_q     <= DIGIT_TOP[1:0];
						dig_q   <= '0;
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					w_q       <= sub_res;
					dig_q[k_q] <= ge;
					k_q       <= k_q - 1'b1;
					if (k_q == '0) begin
						if (cnt_q == '0) begin
							done_q           <= 1'b1;
							negative_q       <= neg_q;
							integer_part_q   <= quo_q;
							digit_q          <= {dig_q[DIGIT_W-1:1], ge};
							ended_q          <= 1'b0;
							divide_by_zero_q <= 1'b0;
							state_q          <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign negative       = negative_q;
	assign integer_part   = integer_part_q;
	assign digit          = digit_q;
	assign ended          = ended_q;
	assign divide_by_zero = divide_by_zero_q;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives digit positions into fraction_decimal_digit under a series of
// numerator/denominator settings written over APB. Each accepted transaction
// is predicted by long division with modular powers of ten, and every done
// strobe is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

	import fdd_pkg::*;

	localparam int POS_W          = 16;
	localparam int WATCHDOG_LIMIT = 1400000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int RANDOM_PHASES  = 11;
	localparam int PHASE_ITEMS    = 140;

	localparam logic [ADDR_W-1:0] ADDR_NUMERATOR   = {REG_NUMERATOR, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_DENOMINATOR = {REG_DENOMINATOR, 2'b00};

	typedef enum int {
		FRAC_RANDOM,
		FRAC_SMALL,
		FRAC_TERMINATING,
		FRAC_EXTREME,
		FRAC_ZERO_NUM,
		FRAC_ZERO_DEN
	} frac_kind_t;

	typedef struct packed {
		logic               negative;
		logic [NUM_W-1:0]   integer_part;
		logic [DIGIT_W-1:0] digit;
		logic               ended;
		logic               divide_by_zero;
	} digit_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [NUM_W-1:0]   pwdata;
	logic [NUM_W-1:0]   prdata;
	logic               pready;
	logic               start;
	logic [POS_W-1:0]   position;
	logic               busy;
	logic               done;
	logic               negative;
	logic [NUM_W-1:0]   integer_part;
	logic [DIGIT_W-1:0] digit;
	logic               ended;
	logic               divide_by_zero;

	logic [NUM_W-1:0] model_numerator;
	logic [NUM_W-1:0] model_denominator;
	digit_result_t    expected_digits[$];
	digit_result_t    want_digit;
	int               errors;
	int               idle_cycles;
	bit               no_gaps;

	fraction_decimal_digit #(
		.POSITION_BITS(POS_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.position(position),
		.busy(busy),
		.done(done),
		.negative(negative),
		.integer_part(integer_part),
		.digit(digit),
		.ended(ended),
		.divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [NUM_W-1:0] abs_value(input logic [NUM_W-1:0] v);
		return v[NUM_W-1] ? ~v + 1'b1 : v;
	endfunction

	// digit at pos: floor(10 * ((|n| mod |d|) * 10^pos mod |d|) / |d|)
	function automatic digit_result_t expand_digit(input logic [POS_W-1:0] pos);
		longint unsigned an;
		longint unsigned ad;
		longint unsigned rem;
		longint unsigned base;
		longint unsigned power;
		int unsigned     e;
		digit_result_t   r;
		r = '0;
		if (model_denominator == '0) begin
			r.divide_by_zero = 1'b1;
			return r;
		end
		an    = 64'(abs_value(model_numerator));
		ad    = 64'(abs_value(model_denominator));
		base  = 64'd10 % ad;
		power = 64'd1 % ad;
		e     = 32'(pos);
		while (e != 0) begin
			if (e[0])
				power = (power * base) % ad;
			base = (base * base) % ad;
			e    = e >> 1;
		end
		rem            = ((an % ad) * power) % ad;
		r.negative     = (model_numerator != '0) &&
		                 (model_numerator[NUM_W-1] ^ model_denominator[NUM_W-1]);
		r.integer_part = NUM_W'(an / ad);
		r.digit        = DIGIT_W'((rem * 10) / ad);
		r.ended        = (rem == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
	                           input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// result checking first, then prediction of a newly accepted transaction
	always @(posedge clk) begin
		if (done) begin
			if (expected_digits.size() == 0) begin
				errors++;
				$display("%0t: result with no transaction outstanding, expected none, actual %h",
				         $time, {negative, integer_part, digit, ended, divide_by_zero});
			end else begin
				want_digit = expected_digits.pop_front();
				check_field("negative", want_digit.negative, negative);
				check_field("integer_part", want_digit.integer_part, integer_part);
				check_field("digit", want_digit.digit, digit);
				check_field("ended", want_digit.ended, ended);
				check_field("divide_by_zero", want_digit.divide_by_zero, divide_by_zero);
			end
		end
		if (arst_n && start && !busy)
			expected_digits.insert(expected_digits.size(), expand_digit(position));
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fraction_decimal_digit test failed");
			$finish;
		end
	end

	task automatic send_position(input logic [POS_W-1:0] pos);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    = 1'b1;
		position = pos;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic settle;
		start = 1'b0;
		while (expected_digits.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [NUM_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		if (addr == ADDR_NUMERATOR)
			model_numerator = value;
		else
			model_denominator = value;
		// read back
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			errors++;
			$display("%0t: readback mismatch at %0d, expected %h, actual %h",
			         $time, addr, value, prdata);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_fraction(input logic [NUM_W-1:0] num, input logic [NUM_W-1:0] den);
		settle();
		write_reg(ADDR_NUMERATOR, num);
		write_reg(ADDR_DENOMINATOR, den);
	endtask

	task automatic test_reset_fraction;
		send_position(16'd0);
		send_position(16'd1);
		send_position(16'hffff);
	endtask

	task automatic test_signs;
		set_fraction(-355, 113);
		send_position(16'd0);
		send_position(16'd3);
		set_fraction(355, -113);
		send_position(16'd1);
		set_fraction(-355, -113);
		send_position(16'd2);
	endtask

	task automatic test_extremes;
		set_fraction(32'h8000_0000, 32'd1);
		send_position(16'd0);
		send_position(16'hffff);
		set_fraction(32'h8000_0000, 32'hffff_ffff);
		send_position(16'd5);
		set_fraction(32'h7fff_ffff, 32'h8000_0000);
		send_position(16'd0);
		send_position(16'd9);
		send_position(16'd40);
		set_fraction(32'h8000_0000, 32'h8000_0000);
		send_position(16'd0);
		set_fraction(32'd1, 32'h7fff_ffff);
		send_position(16'd0);
		send_position(16'd12);
	endtask

	task automatic test_zero_numerator;
		set_fraction(32'd0, -7);
		send_position(16'd0);
		send_position(16'h5555);
	endtask

	task automatic test_zero_denominator;
		set_fraction(-5, 32'd0);
		send_position(16'd0);
		send_position(16'haaaa);
	endtask

	task automatic test_terminating;
		set_fraction(32'd1, 32'd8);
		send_position(16'd2);
		send_position(16'd3);
		set_fraction(-3, 32'd40);
		send_position(16'd2);
		send_position(16'd3);
	endtask

	task automatic test_random;
		frac_kind_t       kind;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
		logic [NUM_W-1:0] corner[5];
		logic [POS_W-1:0] pos;
		bit               wide;
		int               pick;
		corner = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1, 32'h8000_0001};
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			kind = (phase == 0) ? FRAC_EXTREME : frac_kind_t'($urandom_range(0, 5));
			case (kind)
				FRAC_RANDOM: begin
					num = $urandom;
					den = $urandom;
				end
				FRAC_SMALL: begin
					num = $urandom_range(0, 2000) - 1000;
					den = $urandom_range(1, 300);
					if ($urandom_range(0, 1))
						den = -den;
				end
				FRAC_TERMINATING: begin
					num = $urandom;
					den = 32'd1 << $urandom_range(0, 10);
					repeat ($urandom_range(0, 6)) den = den * 5;
					if ($urandom_range(0, 1))
						den = -den;
				end
				FRAC_EXTREME: begin
					num = corner[$urandom_range(0, 4)];
					den = corner[$urandom_range(0, 4)];
				end
				FRAC_ZERO_NUM: begin
					num = '0;
					den = $urandom | 32'd1;
				end
				default: begin
					num = $urandom;
					den = '0;
				end
			endcase
			wide = (kind == FRAC_TERMINATING) || (kind == FRAC_ZERO_NUM) ||
			       (kind == FRAC_ZERO_DEN);
			set_fraction(num, den);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (wide && pick < 10)
					pos = POS_W'($urandom);
				else if (pick < 15)
					pos = POS_W'($urandom_range(0, 250));
				else
					pos = POS_W'($urandom_range(0, 40));
				send_position(pos);
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		start             = 1'b0;
		position          = '0;
		errors            = 0;
		idle_cycles       = 0;
		no_gaps           = 1'b0;
		model_numerator   = NUMERATOR_RESET;
		model_denominator = DENOMINATOR_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_fraction();
		test_signs();
		test_extremes();
		test_zero_numerator();
		test_zero_denominator();
		test_terminating();
		test_random();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("fraction_decimal_digit test passed");
		else
			$display("fraction_decimal_digit test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fdd_pkg.sv
rtl/fraction_decimal_digit.sv
bench/testbench.sv
